FILE: hdl/usv_pkg.sv
// Shared types and constants of the UV sphere vertex generator.
`default_nettype none
package usv_pkg;

  localparam int SEG_W     = 11;
  localparam int FRAC_BITS = 14;
  localparam int OUT_W     = FRAC_BITS + 2;
  localparam int TEX_W     = FRAC_BITS + 1;

  localparam int PHASE_W   = 32;
  localparam int DIV_QW    = PHASE_W + 1;
  localparam int DIV_BPS   = 4;
  localparam int DIV_ST    = (DIV_QW + DIV_BPS - 1) / DIV_BPS;
  localparam int DIV_QP    = DIV_ST * DIV_BPS;

  localparam int SIN_STEPS = 5;
  localparam int COS_STEPS = 6;
  localparam int KERN_LAT  = 4 + 3 * COS_STEPS + 1;
  localparam int OUT_LAT   = 2;

  localparam logic [30:0] HALF_PI_Q31 = 31'h6487ED51;
  localparam logic [30:0] Q_ONE       = 31'h40000000;

  localparam int SEG_MIN   = 6;
  localparam int SEG_RESET = 32;

  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } sm_t;

  typedef struct packed {
    logic [SEG_W-1:0] ring_index;
    logic [SEG_W-1:0] segment_index;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] pos_x;
    logic signed [OUT_W-1:0] pos_y;
    logic signed [OUT_W-1:0] pos_z;
    logic signed [OUT_W-1:0] tan_x;
    logic signed [OUT_W-1:0] tan_y;
    logic signed [OUT_W-1:0] tan_z;
    logic signed [OUT_W-1:0] bitan_x;
    logic signed [OUT_W-1:0] bitan_y;
    logic signed [OUT_W-1:0] bitan_z;
    logic        [TEX_W-1:0] tex_u;
    logic        [TEX_W-1:0] tex_v;
  } res_t;

  function automatic logic [7:0] sin_div(input int i);
    case (i)
      0:       return 8'd110;
      1:       return 8'd72;
      2:       return 8'd42;
      3:       return 8'd20;
      default: return 8'd6;
    endcase
  endfunction

  function automatic logic [7:0] cos_div(input int i);
    case (i)
      0:       return 8'd132;
      1:       return 8'd90;
      2:       return 8'd56;
      3:       return 8'd30;
      4:       return 8'd12;
      default: return 8'd2;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: hdl/usv_if.sv
// Request channels of the UV sphere vertex generator.
`default_nettype none
interface usv_in_if;
  logic         valid;
  logic         ready;
  usv_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface usv_out_if;
  logic          valid;
  logic          ready;
  usv_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface usv_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [usv_pkg::SEG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/usv_div.sv
// Pipelined restoring divider, four quotient bits per stage.
`default_nettype none
module usv_div #(
  parameter int DW = 11
) (
  input  wire logic                                   clk,
  input  wire logic [usv_pkg::DIV_ST-1:0]             en,
  input  wire logic [usv_pkg::DIV_QP+DW-1:0]          num_i,
  input  wire logic [DW-1:0]                          den_i,
  output logic      [usv_pkg::DIV_QW-1:0]             quo_o
);
  localparam int ST = usv_pkg::DIV_ST;
  localparam int QP = usv_pkg::DIV_QP;

  logic [DW-1:0] rem_r [ST];
  logic [QP-1:0] low_r [ST];
  logic [QP-1:0] quo_r [ST];

  for (genvar g = 0; g < ST; g++) begin : g_st
    logic [DW-1:0] rem_in, rem_nxt;
    logic [QP-1:0] low_in, low_nxt, quo_in, quo_nxt;

    if (g == 0) begin : g_first
      assign rem_in = num_i[QP+DW-1:QP];
      assign low_in = num_i[QP-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign low_in = low_r[g-1];
      assign quo_in = quo_r[g-1];
    end

    always_comb begin
      logic [DW:0] t;
      rem_nxt = rem_in;
      low_nxt = low_in;
      quo_nxt = quo_in;
      for (int j = 0; j < usv_pkg::DIV_BPS; j++) begin
        t       = {rem_nxt, low_nxt[QP-1]};
        low_nxt = low_nxt << 1;
        quo_nxt = quo_nxt << 1;
        if (t >= {1'b0, den_i}) begin
          t          = t - {1'b0, den_i};
          quo_nxt[0] = 1'b1;
        end
        rem_nxt = t[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        rem_r[g] <= rem_nxt;
        low_r[g] <= low_nxt;
        quo_r[g] <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[ST-1][usv_pkg::DIV_QW-1:0];
endmodule
`default_nettype wire

FILE: hdl/usv_sincos.sv
// Pipelined sine and cosine of a 32-bit turn phase, Q30 sign and magnitude.
`default_nettype none
module usv_sincos (
  input  wire logic                             clk,
  input  wire logic [usv_pkg::KERN_LAT-1:0]     en,
  input  wire logic [usv_pkg::PHASE_W-1:0]      phase_i,
  output usv_pkg::sm_t                          sin_o,
  output usv_pkg::sm_t                          cos_o
);
  localparam int NS  = usv_pkg::COS_STEPS;
  localparam int LST = usv_pkg::KERN_LAT - 1;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } side_t;

  side_t       side_r [LST];
  logic [29:0] rr_r;
  logic [60:0] prod_r;
  logic [59:0] xx_r;

  logic [60:0] as_r  [NS];
  logic [60:0] ac_r  [NS];
  logic [30:0] bs_r  [NS];
  logic [29:0] bc_r  [NS];
  logic [61:0] bms_r [usv_pkg::SIN_STEPS];
  logic [61:0] bmc_r [NS];
  logic [30:0] ts_r  [NS];
  logic [30:0] tc_r  [NS];

  usv_pkg::sm_t sin_r, cos_r;

  function automatic logic [30:0] horner_t(input logic [29:0] y, input logic [61:0] m,
                                           input logic [7:0] k);
    logic [29:0] qe;
    logic [37:0] rem;
    logic [29:0] q;
    qe  = m[61:32];
    rem = 38'(y) - 38'(qe) * 38'(k);
    q   = qe + 30'(rem >= 38'(k));
    return usv_pkg::Q_ONE - 31'(q);
  endfunction

  logic [29:0] r0;
  logic        swap0;
  logic [29:0] x_nxt;
  assign r0    = phase_i[29:0];
  assign swap0 = r0 > 30'h20000000;
  assign x_nxt = 30'((prod_r + 61'h40000000) >> 31);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rr_r      <= swap0 ? (~r0 + 30'd1) : r0;
      side_r[0] <= '{x: '0, x2: '0, quad: phase_i[31:30], swap: swap0};
    end
    if (en[1]) begin
      prod_r    <= 61'(rr_r) * 61'(usv_pkg::HALF_PI_Q31);
      side_r[1] <= side_r[0];
    end
    if (en[2]) begin
      xx_r      <= 60'(x_nxt) * 60'(x_nxt);
      side_r[2] <= '{x: x_nxt, x2: side_r[1].x2, quad: side_r[1].quad,
                     swap: side_r[1].swap};
    end
    if (en[3]) begin
      side_r[3] <= '{x: side_r[2].x, x2: 30'((61'(xx_r) + 61'h20000000) >> 30),
                     quad: side_r[2].quad, swap: side_r[2].swap};
    end
  end

  for (genvar g = 4; g < LST; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[g]) begin
        side_r[g] <= side_r[g-1];
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam int          EA = 4 + 3 * i;
    localparam logic [7:0]  KC = usv_pkg::cos_div(i);
    localparam logic [31:0] MC = 32'((64'd1 << 32) / KC);
    logic [30:0] ts_in, tc_in;

    if (i == 0) begin : g_first
      assign ts_in = usv_pkg::Q_ONE;
      assign tc_in = usv_pkg::Q_ONE;
    end else begin : g_next
      assign ts_in = ts_r[i-1];
      assign tc_in = tc_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en[EA]) begin
        ac_r[i] <= 61'(side_r[EA-1].x2) * 61'(tc_in);
      end
      if (en[EA+1]) begin
        bc_r[i]  <= 30'(ac_r[i] >> 30);
        bmc_r[i] <= 62'(30'(ac_r[i] >> 30)) * 62'(MC);
      end
      if (en[EA+2]) begin
        tc_r[i] <= horner_t(bc_r[i], bmc_r[i], KC);
      end
    end

    if (i < usv_pkg::SIN_STEPS) begin : g_sin
      localparam logic [7:0]  KS = usv_pkg::sin_div(i);
      localparam logic [31:0] MS = 32'((64'd1 << 32) / KS);
      always_ff @(posedge clk) begin
        if (en[EA]) begin
          as_r[i] <= 61'(side_r[EA-1].x2) * 61'(ts_in);
        end
        if (en[EA+1]) begin
          bs_r[i]  <= 31'(as_r[i] >> 30);
          bms_r[i] <= 62'(30'(as_r[i] >> 30)) * 62'(MS);
        end
        if (en[EA+2]) begin
          ts_r[i] <= horner_t(bs_r[i][29:0], bms_r[i], KS);
        end
      end
    end else begin : g_sin_fin
      always_ff @(posedge clk) begin
        if (en[EA]) begin
          as_r[i] <= 61'(side_r[EA-1].x) * 61'(ts_in);
        end
        if (en[EA+1]) begin
          bs_r[i] <= 31'((as_r[i] + 61'h20000000) >> 30);
        end
        if (en[EA+2]) begin
          ts_r[i] <= bs_r[i];
        end
      end
    end
  end

  logic [30:0] s0, c0;
  usv_pkg::sm_t sin_nxt, cos_nxt;
  assign s0 = side_r[LST-1].swap ? tc_r[NS-1] : ts_r[NS-1];
  assign c0 = side_r[LST-1].swap ? ts_r[NS-1] : tc_r[NS-1];

  always_comb begin
    case (side_r[LST-1].quad)
      2'd0: begin
        sin_nxt = '{neg: 1'b0, mag: s0};
        cos_nxt = '{neg: 1'b0, mag: c0};
      end
      2'd1: begin
        sin_nxt = '{neg: 1'b0, mag: c0};
        cos_nxt = '{neg: 1'b1, mag: s0};
      end
      2'd2: begin
        sin_nxt = '{neg: 1'b1, mag: s0};
        cos_nxt = '{neg: 1'b1, mag: c0};
      end
      default: begin
        sin_nxt = '{neg: 1'b1, mag: c0};
        cos_nxt = '{neg: 1'b0, mag: s0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[LST]) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;
endmodule
`default_nettype wire

FILE: hdl/usv_delay.sv
// Enable-per-stage delay line for side data.
`default_nettype none
module usv_delay #(
  parameter int W = 30,
  parameter int N = 23
) (
  input  wire logic         clk,
  input  wire logic [N-1:0] en,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] d_o
);
  logic [W-1:0] d_r [N];

  for (genvar g = 0; g < N; g++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en[g]) begin
        if (g == 0) begin
          d_r[g] <= d_i;
        end else begin
          d_r[g] <= d_r[(g == 0) ? 0 : g-1];
        end
      end
    end
  end

  assign d_o = d_r[N-1];
endmodule
`default_nettype wire

FILE: hdl/usv_out.sv
// Vector products, rounding to the output format and the result register.
`default_nettype none
module usv_out (
  input  wire logic                          clk,
  input  wire logic [usv_pkg::OUT_LAT-1:0]   en,
  input  wire usv_pkg::sm_t                  st_i,
  input  wire usv_pkg::sm_t                  ct_i,
  input  wire usv_pkg::sm_t                  sp_i,
  input  wire usv_pkg::sm_t                  cp_i,
  input  wire logic [usv_pkg::TEX_W-1:0]     tex_u_i,
  input  wire logic [usv_pkg::TEX_W-1:0]     tex_v_i,
  output usv_pkg::res_t                      res_o
);
  localparam int OW  = usv_pkg::OUT_W;
  localparam int SH1 = 30 - usv_pkg::FRAC_BITS;
  localparam int SH2 = 60 - usv_pkg::FRAC_BITS;

  typedef struct packed {
    logic        neg;
    logic [61:0] mag;
  } prod_t;

  prod_t        stcp_r, stsp_r, ctcp_r, ctsp_r;
  usv_pkg::sm_t st_r, ct_r, sp_r, cp_r;
  logic [usv_pkg::TEX_W-1:0] tu_r, tv_r;
  usv_pkg::res_t res_r;

  function automatic prod_t mul(input usv_pkg::sm_t a, input usv_pkg::sm_t b);
    prod_t p;
    p.neg = a.neg ^ b.neg;
    p.mag = 62'(a.mag) * 62'(b.mag);
    return p;
  endfunction

  function automatic logic [OW-1:0] rnd_p(input prod_t p);
    logic [OW-1:0] v;
    v = OW'((p.mag + (62'd1 << (SH2 - 1))) >> SH2);
    return p.neg ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [OW-1:0] rnd_s(input logic neg, input logic [30:0] mag);
    logic [OW-1:0] v;
    v = OW'((mag + (31'd1 << (SH1 - 1))) >> SH1);
    return neg ? (~v + 1'b1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      stcp_r <= mul(st_i, cp_i);
      stsp_r <= mul(st_i, sp_i);
      ctcp_r <= mul(ct_i, cp_i);
      ctsp_r <= mul(ct_i, sp_i);
      st_r   <= st_i;
      ct_r   <= ct_i;
      sp_r   <= sp_i;
      cp_r   <= cp_i;
      tu_r   <= tex_u_i;
      tv_r   <= tex_v_i;
    end
    if (en[1]) begin
      res_r.pos_x   <= rnd_p(stcp_r);
      res_r.pos_y   <= rnd_s(~ct_r.neg, ct_r.mag);
      res_r.pos_z   <= rnd_p(stsp_r);
      res_r.tan_x   <= rnd_s(sp_r.neg, sp_r.mag);
      res_r.tan_y   <= '0;
      res_r.tan_z   <= rnd_s(~cp_r.neg, cp_r.mag);
      res_r.bitan_x <= rnd_p(ctcp_r);
      res_r.bitan_y <= rnd_s(st_r.neg, st_r.mag);
      res_r.bitan_z <= rnd_p(ctsp_r);
      res_r.tex_u   <= tu_r;
      res_r.tex_v   <= tv_r;
    end
  end

  assign res_o = res_r;
endmodule
`default_nettype wire

FILE: hdl/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator.
//
// Channels: in_ch takes one grid point (ring_index, segment_index) per
// request; out_ch returns one vertex (position, tangent, bitangent, texture
// coordinates) per request, in order. cfg_ch writes the segment count; it
// is always ready and the value is clamped to 6..MAX_SEGMENTS on write.
// Write it only while no request is in flight.
// Pipeline: 35 register stages in all: one input stage, nine divider
// stages (four quotient bits each), 23 sine/cosine stages (Horner chain
// of three stages per term) and two output stages.
// Throughput: one request per cycle while out_ch is ready or any stage is empty.
// Reset: all stage valid bits clear, segment count returns to 32.
// Stall: a stage advances while out_ch is ready or it or any later stage
// has room, so bubbles close up and new requests are still taken until all
// 35 stages hold a request; nothing is dropped or repeated.
`default_nettype none
module uv_sphere_vertex_generator #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  usv_in_if.sink    in_ch,
  usv_out_if.source out_ch,
  usv_cfg_if.sink   cfg_ch
);
  localparam int SW   = $clog2(MAX_SEGMENTS + 1);
  localparam int QP   = usv_pkg::DIV_QP;
  localparam int DST  = usv_pkg::DIV_ST;
  localparam int KL   = usv_pkg::KERN_LAT;
  localparam int L    = 1 + DST + KL + usv_pkg::OUT_LAT;
  localparam int KB   = 1 + DST;
  localparam int OB   = KB + KL;
  localparam int F    = usv_pkg::FRAC_BITS;
  localparam int TW   = usv_pkg::TEX_W;

  logic [SW-1:0] seg_r, seg_nxt;
  logic [L-1:0]  vld_r;
  logic [L-1:0]  en;

  logic [QP+SW-1:0] phi_num_r, tu_num_r, tv_num_r;
  logic [QP+SW:0]   th_num_r;

  logic [usv_pkg::DIV_QW-1:0] phi_q, th_q, tu_q, tv_q;
  usv_pkg::sm_t st, ct, sp, cp;
  logic [2*TW-1:0] tex_d;

  logic [31:0] cfg32;
  assign cfg32   = 32'(cfg_ch.data);
  assign seg_nxt = (cfg32 < 32'(usv_pkg::SEG_MIN)) ? SW'(usv_pkg::SEG_MIN) :
                   (cfg32 > 32'(MAX_SEGMENTS))     ? SW'(MAX_SEGMENTS) : SW'(cfg32);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SW'(usv_pkg::SEG_RESET);
    end else if (cfg_ch.valid) begin
      seg_r <= seg_nxt;
    end
  end

  always_comb begin
    for (int g = 0; g < L; g++) begin
      en[g] = out_ch.ready | ~&(vld_r | ({L{1'b1}} >> (L - g)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int g = 0; g < L; g++) begin
        if (en[g]) begin
          vld_r[g] <= (g == 0) ? in_ch.valid : vld_r[(g == 0) ? 0 : g - 1];
        end
      end
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = vld_r[L-1];

  logic [SW-1:0] m_c, n_c;
  assign m_c = (32'(in_ch.data.ring_index) > 32'(seg_r)) ? seg_r :
               SW'(in_ch.data.ring_index);
  assign n_c = (32'(in_ch.data.segment_index) > 32'(seg_r)) ? seg_r :
               SW'(in_ch.data.segment_index);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      phi_num_r <= (QP+SW)'((64'(n_c) << 32) + 64'(seg_r >> 1));
      th_num_r  <= (QP+SW+1)'((64'(m_c) << 32) + 64'(seg_r));
      tu_num_r  <= (QP+SW)'((64'(seg_r - n_c) << F) + 64'(seg_r >> 1));
      tv_num_r  <= (QP+SW)'((64'(m_c) << F) + 64'(seg_r >> 1));
    end
  end

  usv_div #(.DW(SW)) u_div_phi (
    .clk(clk), .en(en[DST:1]), .num_i(phi_num_r), .den_i(seg_r), .quo_o(phi_q)
  );
  usv_div #(.DW(SW+1)) u_div_th (
    .clk(clk), .en(en[DST:1]), .num_i(th_num_r), .den_i({seg_r, 1'b0}), .quo_o(th_q)
  );
  usv_div #(.DW(SW)) u_div_tu (
    .clk(clk), .en(en[DST:1]), .num_i(tu_num_r), .den_i(seg_r), .quo_o(tu_q)
  );
  usv_div #(.DW(SW)) u_div_tv (
    .clk(clk), .en(en[DST:1]), .num_i(tv_num_r), .den_i(seg_r), .quo_o(tv_q)
  );

  usv_sincos u_sc_th (
    .clk(clk), .en(en[OB-1:KB]), .phase_i(th_q[usv_pkg::PHASE_W-1:0]),
    .sin_o(st), .cos_o(ct)
  );
  usv_sincos u_sc_phi (
    .clk(clk), .en(en[OB-1:KB]), .phase_i(phi_q[usv_pkg::PHASE_W-1:0]),
    .sin_o(sp), .cos_o(cp)
  );

  usv_delay #(.W(2*TW), .N(KL)) u_tex_dly (
    .clk(clk), .en(en[OB-1:KB]), .d_i({tu_q[TW-1:0], tv_q[TW-1:0]}), .d_o(tex_d)
  );

  usv_out u_out (
    .clk(clk), .en(en[L-1:OB]),
    .st_i(st), .ct_i(ct), .sp_i(sp), .cp_i(cp),
    .tex_u_i(tex_d[2*TW-1:TW]), .tex_v_i(tex_d[TW-1:0]),
    .res_o(out_ch.data)
  );

`ifndef SYNTH
  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted request did not enter the first stage");
  a_full_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&vld_r))
    else $error("input blocked while a stage is empty");
  a_seg_range : assert property (@(posedge clk) disable iff (!rst_n)
    (32'(seg_r) >= 32'(usv_pkg::SEG_MIN)) && (32'(seg_r) <= 32'(MAX_SEGMENTS)))
    else $error("segment count out of range");
`endif
endmodule
`default_nettype wire

FILE: dv/uv_sphere_vertex_generator_tb.sv
// Self-checking testbench of the UV sphere vertex generator.
`default_nettype none
module uv_sphere_vertex_generator_tb;

  localparam int LATENCY = 35;
  localparam int WATCHDOG_LIMIT = 20000;

  class vertex_scoreboard;
    usv_pkg::res_t pending[$];
    int unsigned seg_reg;
    int errors;

    function new();
      seg_reg = usv_pkg::SEG_RESET;
      errors = 0;
    endfunction

    function void octant(input longint unsigned r, output longint s, output longint c);
      longint unsigned x, x2, t;
      x = (r * 64'h6487ED51 + (64'd1 << 30)) >> 31;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      t = 64'd1 << 30;
      for (int i = 0; i < 5; i++)
        t = (64'd1 << 30) - (x2 * t) / (64'(usv_pkg::sin_div(i)) << 30);
      s = longint'((x * t + (64'd1 << 29)) >> 30);
      t = 64'd1 << 30;
      for (int i = 0; i < 6; i++)
        t = (64'd1 << 30) - (x2 * t) / (64'(usv_pkg::cos_div(i)) << 30);
      c = longint'(t);
    endfunction

    function void turn(input longint unsigned a, input longint unsigned d,
                       output longint s, output longint c);
      longint unsigned p, r;
      longint s0, c0;
      p = (((a << 32) + (d >> 1)) / d) & 64'hFFFF_FFFF;
      r = p & ((64'd1 << 30) - 1);
      if (r <= (64'd1 << 29)) octant(r, s0, c0);
      else octant((64'd1 << 30) - r, c0, s0);
      case (p[31:30])
        2'd0: begin s = s0; c = c0; end
        2'd1: begin s = c0; c = -s0; end
        2'd2: begin s = -s0; c = -c0; end
        default: begin s = -c0; c = s0; end
      endcase
    endfunction

    function logic [usv_pkg::OUT_W-1:0] round_one(input longint v);
      longint unsigned mag;
      mag = v < 0 ? -v : v;
      mag = (mag + (64'd1 << 15)) >> 16;
      return 16'(v < 0 ? -mag : mag);
    endfunction

    function logic [usv_pkg::OUT_W-1:0] round_mul(input longint a, input longint b);
      longint unsigned ma, mb, mag;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      mag = ma * mb;
      return 16'((((a < 0) != (b < 0)) && mag != 0) ? -((mag + (64'd1 << 45)) >> 46)
                                                     : ((mag + (64'd1 << 45)) >> 46));
    endfunction

    function void note_request(usv_pkg::in_t req);
      longint unsigned s, m, n;
      longint st, ct, sp, cp;
      usv_pkg::res_t r;
      s = seg_reg;
      if (s < usv_pkg::SEG_MIN) s = usv_pkg::SEG_MIN;
      if (s > 1024) s = 1024;
      m = req.ring_index;
      n = req.segment_index;
      if (m > s) m = s;
      if (n > s) n = s;
      turn(m, 2 * s, st, ct);
      turn(n, s, sp, cp);
      r.pos_x = round_mul(st, cp);
      r.pos_y = round_one(-ct);
      r.pos_z = round_mul(st, sp);
      r.tan_x = round_one(sp);
      r.tan_y = '0;
      r.tan_z = round_one(-cp);
      r.bitan_x = round_mul(ct, cp);
      r.bitan_y = round_one(st);
      r.bitan_z = round_mul(ct, sp);
      r.tex_u = 15'((((s - n) << usv_pkg::FRAC_BITS) + (s >> 1)) / s);
      r.tex_v = 15'(((m << usv_pkg::FRAC_BITS) + (s >> 1)) / s);
      pending = {pending, r};
    endfunction

    function void report(string field, logic [15:0] e, logic [15:0] a);
      $display("%0t: %s expected %h actual %h", $time, field, e, a);
      errors++;
    endfunction

    function void check_vertex(usv_pkg::res_t got);
      usv_pkg::res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected vertex %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.pos_x !== exp_r.pos_x) report("pos_x", exp_r.pos_x, got.pos_x);
      if (got.pos_y !== exp_r.pos_y) report("pos_y", exp_r.pos_y, got.pos_y);
      if (got.pos_z !== exp_r.pos_z) report("pos_z", exp_r.pos_z, got.pos_z);
      if (got.tan_x !== exp_r.tan_x) report("tan_x", exp_r.tan_x, got.tan_x);
      if (got.tan_y !== exp_r.tan_y) report("tan_y", exp_r.tan_y, got.tan_y);
      if (got.tan_z !== exp_r.tan_z) report("tan_z", exp_r.tan_z, got.tan_z);
      if (got.bitan_x !== exp_r.bitan_x) report("bitan_x", exp_r.bitan_x, got.bitan_x);
      if (got.bitan_y !== exp_r.bitan_y) report("bitan_y", exp_r.bitan_y, got.bitan_y);
      if (got.bitan_z !== exp_r.bitan_z) report("bitan_z", exp_r.bitan_z, got.bitan_z);
      if (got.tex_u !== exp_r.tex_u) report("tex_u", 16'(exp_r.tex_u), 16'(got.tex_u));
      if (got.tex_v !== exp_r.tex_v) report("tex_v", 16'(exp_r.tex_v), 16'(got.tex_v));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int idle_cycles = 0;
  vertex_scoreboard sb = new();

  usv_in_if in_ch();
  usv_out_if out_ch();
  usv_cfg_if cfg_ch();

  uv_sphere_vertex_generator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_vertex(out_ch.data);
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_point(logic [usv_pkg::SEG_W-1:0] m, logic [usv_pkg::SEG_W-1:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{ring_index: m, segment_index: n};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_segments(logic [usv_pkg::SEG_W-1:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.seg_reg = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_points(int count);
    int unsigned s;
    s = sb.seg_reg < usv_pkg::SEG_MIN ? usv_pkg::SEG_MIN :
        (sb.seg_reg > 1024 ? 1024 : sb.seg_reg);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0)
        send_point(11'($urandom_range(2047)), 11'($urandom_range(2047)));
      else
        send_point(11'($urandom_range(s)), 11'($urandom_range(s)));
    end
  endtask

  initial begin
    int unsigned seg_list[8] = '{6, 7, 12, 100, 1024, 2047, 0, 1023};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_point(0, 0);
    send_point(32, 32);
    send_point(16, 8);
    send_point(16, 16);
    send_point(16, 24);
    send_point(0, 5);
    send_point(32, 7);
    send_point(2047, 2047);
    send_point(33, 0);
    send_point(0, 33);
    send_point(1024, 1024);
    send_point(8, 4);
    send_point(24, 12);
    for (int i = 0; i < usv_pkg::SEG_W; i++) send_point(11'(1 << i), 11'(~(1 << i)));
    drain();

    foreach (seg_list[k]) begin
      write_segments(11'(seg_list[k]));
      case (k % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 63; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      send_point(0, 0);
      send_point(2047, 2047);
      random_points(100);
    end

    write_segments(32);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end
      random_points(100);
    join
    drain();
    random_points(60);

    drain();
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
